>>> rtl/int_to_decimal_ascii_assert.svh
//------------------------------------------------------------------------------
// int_to_decimal_ascii assertion macros
// Clocked assertion shorthands used by the checker file of this block.
//------------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define ITDA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itda assertion failed");

// Implication whose consequent is checked in the next cycle.
`define ITDA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itda assertion failed");

`endif

>>> rtl/itda_pkg.sv
//------------------------------------------------------------------------------
// itda_pkg
// Types and constants shared by the integer to decimal text converter.
//------------------------------------------------------------------------------
package itda_pkg;

	localparam int VALUE_W   = 64;
	localparam int BIT_CNT_W = 6;
	localparam int CHAR_W    = 8;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic clear;
		logic dabble;
		logic shift;
	} cell_ctrl_t;

endpackage

>>> rtl/int_to_decimal_ascii.sv
//------------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts one 64-bit integer to its decimal ASCII text, one character per
// output request.
//------------------------------------------------------------------------------
// A request carries the 64-bit pattern in s_axis_tdata and the signed flag in
// s_axis_tuser; the text leaves on m_axis, a leading minus for negative values
// and then the digits most significant first, with m_axis_tlast on the final
// one. The magnitude enters a chain of MAX_DIGITS BCD cells one bit per cycle;
// then the chain shifts up one digit per cycle while the output is not stalled,
// dropping leading zeros and sending the rest; for negative values a minus
// sign goes out first. The next request is taken once the last character is
// in the output register.
module int_to_decimal_ascii #(
	parameter int MAX_DIGITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [63:0] value_bits
	input  logic [0:0]  s_axis_tuser,  // [0] value_signed
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] ascii_char
	output logic        m_axis_tlast   // last_char
);
	import itda_pkg::*;

	localparam int DCW = $clog2(MAX_DIGITS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SIGN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t               state_q, state_d;
	logic [VALUE_W-1:0]   mag_q;
	logic                 neg_q;
	logic                 ovf_q;
	logic                 started_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [DCW-1:0]       dig_cnt_q;
	logic                 m_valid_q;
	logic [CHAR_W-1:0]    m_data_q;
	logic                 m_last_q;

	logic                 accept;
	logic                 in_neg;
	logic [VALUE_W-1:0]   in_mag;
	logic                 out_free;
	logic                 skip;
	logic                 emit_fire;
	logic                 sign_fire;
	logic                 conv_done;
	logic                 last_digit;
	cell_ctrl_t           ctrl;
	logic [MAX_DIGITS:0]  carry;
	digit_t               dig [MAX_DIGITS];
	digit_t               dig_in [MAX_DIGITS];
	digit_t               top_digit;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_neg        = s_axis_tuser[0] && s_axis_tdata[VALUE_W-1];
	assign in_mag        = in_neg ? (~s_axis_tdata + 64'd1) : s_axis_tdata;

	assign out_free   = !m_valid_q || m_axis_tready;
	assign top_digit  = dig[MAX_DIGITS-1];
	assign last_digit = (dig_cnt_q == DCW'(1));
	assign skip       = !ovf_q && !started_q && (top_digit == 4'd0) && !last_digit;
	assign emit_fire  = (state_q == ST_EMIT) && !skip && out_free;
	assign sign_fire  = (state_q == ST_SIGN) && out_free;
	assign conv_done  = (state_q == ST_CONV) && (bit_cnt_q == {BIT_CNT_W{1'b1}});

	assign ctrl.clear  = accept;
	assign ctrl.dabble = (state_q == ST_CONV);
	assign ctrl.shift  = (state_q == ST_EMIT) && (skip || emit_fire);

	assign carry[0] = mag_q[VALUE_W-1];

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_bottom
			assign dig_in[i] = '0;
		end else begin : g_upper
			assign dig_in[i] = dig[i-1];
		end

		itda_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.carry_in  (carry[i]),
			.digit_in  (dig_in[i]),
			.carry_out (carry[i+1]),
			.digit_out (dig[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (conv_done) state_d = neg_q ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (sign_fire) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_fire && last_digit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			neg_q     <= 1'b0;
			ovf_q     <= 1'b0;
			started_q <= 1'b0;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				neg_q     <= in_neg;
				ovf_q     <= 1'b0;
				bit_cnt_q <= '0;
			end else if (state_q == ST_CONV) begin
				ovf_q     <= ovf_q | carry[MAX_DIGITS];
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
			end
			if (accept) begin
				started_q <= 1'b0;
			end else if (emit_fire) begin
				started_q <= 1'b1;
			end
			if (conv_done) begin
				dig_cnt_q <= DCW'(MAX_DIGITS);
			end else if (ctrl.shift) begin
				dig_cnt_q <= dig_cnt_q - DCW'(1);
			end
			if (sign_fire || emit_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= in_mag;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
		end
		if (sign_fire) begin
			m_data_q <= CHAR_MINUS;
			m_last_q <= 1'b0;
		end else if (emit_fire) begin
			m_data_q <= CHAR_ZERO + {4'd0, top_digit};
			m_last_q <= last_digit;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

>>> rtl/itda_cell.sv
//------------------------------------------------------------------------------
// itda_cell
// One BCD digit of the conversion chain: shift-and-add-3 while converting,
// plain digit shift toward the top while the text is sent out.
//------------------------------------------------------------------------------
module itda_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  itda_pkg::cell_ctrl_t ctrl,
	input  logic                 carry_in,
	input  itda_pkg::digit_t     digit_in,
	output logic                 carry_out,
	output itda_pkg::digit_t     digit_out
);
	import itda_pkg::*;

	digit_t digit_q;
	digit_t adj;

	assign adj       = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry_out = adj[3];
	assign digit_out = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], carry_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

>>> rtl/itda_checker.sv
//------------------------------------------------------------------------------
// itda_checker
// Port-level checks of the integer to decimal text converter, bound to the
// top level.
//------------------------------------------------------------------------------
`include "int_to_decimal_ascii_assert.svh"

module itda_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast
);
	import itda_pkg::*;

	logic in_fire;
	logic out_char_ok;

	assign in_fire     = s_axis_tvalid && s_axis_tready;
	assign out_char_ok = (m_axis_tdata == CHAR_MINUS)
		|| ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_NINE));

	// A waiting character and its last mark hold until taken.
	`ITDA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// Only a minus sign or a decimal digit ever leaves the block.
	`ITDA_ASSERT_IMP(a_out_char, m_axis_tvalid, out_char_ok)

	// A minus sign always has digits after it.
	`ITDA_ASSERT_IMP(a_minus_not_last, m_axis_tvalid && (m_axis_tdata == CHAR_MINUS),
		!m_axis_tlast)

	// The block works on one request at a time.
	`ITDA_ASSERT_NEXT(a_one_at_a_time, in_fire, !s_axis_tready)

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (.*);

>>> verif/tb_int_to_decimal_ascii.sv
//------------------------------------------------------------------------------
// tb_int_to_decimal_ascii
// Self-checking testbench for the integer to decimal ASCII text converter.
// Each accepted request is run through a local model that produces the expected
// characters, and every character that leaves on the output stream is compared
// with the oldest pending one. Directed extremes come first, then random values
// of several shapes, a long output stall, full-rate traffic and paced requests.
//------------------------------------------------------------------------------
module tb_int_to_decimal_ascii;

	import itda_pkg::*;

	localparam int MAX_DIGITS   = 20;
	localparam int SETTLE_CYC   = 100;
	localparam int DRAIN_LIMIT  = 200000;
	localparam int RUN_LIMIT    = 600000;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;  // [63:0] value_bits
	logic [0:0]  s_axis_tuser  = '0;  // [0] value_signed
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [7:0] ascii_char
	logic        m_axis_tlast;        // last_char

	text_char_t  expected_text[$];
	text_char_t  oldest_char;
	int          mismatch_count = 0;
	int          request_count  = 0;
	int          char_count     = 0;
	int          rx_hold_cycles = 0;
	bit          idle_en        = 1'b1;

	int_to_decimal_ascii #(
		.MAX_DIGITS(MAX_DIGITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * RUN_LIMIT);
		$display("tb_int_to_decimal_ascii: errors");
		$finish;
	end

	task automatic predict_text(input logic [63:0] value, input logic sgn);
		logic [63:0] mag;
		logic [3:0]  digits[MAX_DIGITS];
		logic        neg;
		int          nd;
		text_char_t  c;
		neg = sgn && value[63];
		mag = neg ? (~value + 64'd1) : value;
		nd = 0;
		do begin
			digits[nd] = 4'(mag % 64'd10);
			mag = mag / 64'd10;
			nd++;
		end while (mag != 0 && nd < MAX_DIGITS);
		if (neg) begin
			c.ch = CHAR_MINUS;
			c.last = 1'b0;
			expected_text.push_back(c);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			c.ch = CHAR_ZERO + CHAR_W'(digits[i]);
			c.last = (i == 0);
			expected_text.push_back(c);
		end
	endtask

	// Called at a rising edge; returns at the edge that accepts the request.
	task automatic send_number(input logic [63:0] value, input logic sgn);
		int gap;
		gap = idle_en ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= sgn;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		predict_text(value, sgn);
		request_count++;
	endtask

	task automatic drain_text();
		int waited;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (expected_text.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_text.size() != 0) begin
			$display("%0t: %0d expected characters never arrived", $time,
				expected_text.size());
			mismatch_count++;
			expected_text.delete();
		end
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic draw_number(output logic [63:0] value, output logic sgn);
		logic [63:0] mask;
		logic [63:0] p;
		int          w;
		sgn = 1'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				value = {$urandom, $urandom};
			end
			4, 5: begin
				case ($urandom_range(0, 3))
					0: w = 8;
					1: w = 16;
					2: w = 32;
					default: w = 64;
				endcase
				mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
				value = {$urandom, $urandom} & mask;
				if (sgn && value[w-1]) value = value | ~mask;
			end
			6, 7: begin
				p = 64'd1;
				repeat ($urandom_range(0, 19)) p = p * 64'd10;
				value = p - 64'd1 + 64'($urandom_range(0, 2));
				if (sgn && $urandom_range(0, 1)) value = -value;
			end
			default: begin
				value = 64'($urandom_range(0, 1000));
				if (sgn && $urandom_range(0, 1)) value = -value;
			end
		endcase
	endtask

	// Output side: random stalls, plus a long hold-off when one is requested.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = idle_en ? $urandom_range(0, 4) : 0;
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(negedge clk); while (!m_axis_tvalid);
			@(posedge clk);
		end
	end

	// Outputs only move at rising edges, so the values seen here are the ones
	// accepted at the next edge.
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			char_count++;
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
					$time, m_axis_tdata, m_axis_tlast);
				mismatch_count++;
			end else begin
				oldest_char = expected_text.pop_front();
				if (m_axis_tdata !== oldest_char.ch) begin
					$display("%0t: ascii_char mismatch: expected 0x%02h, actual 0x%02h",
						$time, oldest_char.ch, m_axis_tdata);
					mismatch_count++;
				end
				if (m_axis_tlast !== oldest_char.last) begin
					$display("%0t: last_char mismatch: expected %0b, actual %0b",
						$time, oldest_char.last, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_directed_values();
		send_number(64'd0, 1'b0);
		send_number(64'd0, 1'b1);
		send_number(64'd1, 1'b0);
		send_number(64'd9, 1'b0);
		send_number(64'd10, 1'b1);
		send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		send_number(64'h8000_0000_0000_0000, 1'b1);
		send_number(64'h8000_0000_0000_0000, 1'b0);
		send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		send_number(64'd10000000000000000000, 1'b0);
		send_number(64'd9999999999999999999, 1'b0);
		send_number(64'hFFFF_FFFF_FFFF_FFF6, 1'b1);
		send_number(64'h0000_0000_FFFF_FFFF, 1'b0);
		send_number(64'hFFFF_FFFF_8000_0000, 1'b1);
		send_number(64'h0000_0000_0000_0080, 1'b0);
		send_number(64'hFFFF_FFFF_FFFF_FF80, 1'b1);
		send_number(64'd12345678901234567890, 1'b0);
		send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		send_number(64'h5555_5555_5555_5555, 1'b0);
		drain_text();
	endtask

	task automatic test_random_values(input int count);
		logic [63:0] value;
		logic        sgn;
		repeat (count) begin
			draw_number(value, sgn);
			send_number(value, sgn);
		end
		drain_text();
	endtask

	task automatic test_output_stall();
		logic [63:0] value;
		logic        sgn;
		rx_hold_cycles = 400;
		repeat (30) begin
			draw_number(value, sgn);
			send_number(value, sgn);
		end
		drain_text();
	endtask

	task automatic test_full_rate();
		idle_en = 1'b0;
		test_random_values(60);
		idle_en = 1'b1;
	endtask

	task automatic test_paced_requests();
		logic [63:0] value;
		logic        sgn;
		repeat (20) begin
			draw_number(value, sgn);
			send_number(value, sgn);
			drain_text();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_values();
		test_random_values(300);
		test_output_stall();
		test_full_rate();
		test_paced_requests();
		$display("Converted %0d requests into %0d checked characters,", request_count,
			char_count);
		$display("with extremes, narrow types, a long output stall and full-rate traffic.");
		if (mismatch_count == 0) begin
			$display("tb_int_to_decimal_ascii: clean");
		end else begin
			$display("tb_int_to_decimal_ascii: errors");
		end
		$finish;
	end

endmodule
